// ===== hw/rtl/w3f_pkg.sv =====
// ----------------------------------------------------------------------------
// w3f_pkg: shared types and constants of the 3x3 window filter
// Pixel and border-flag types, mode and register codes, reset values.
// ----------------------------------------------------------------------------
package w3f_pkg;

  localparam int DEF_MAX_WIDTH = 1024;

  localparam int RAW_WID_W = 11;
  localparam int HGT_W     = 16;
  localparam int ROW_W     = 17;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [MODE_W-1:0] MODE_MEAN   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LAPL   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MIN    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MAX    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MEDIAN = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [MODE_W-1:0]    RST_MODE   = MODE_MEAN;
  localparam logic [RAW_WID_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [HGT_W-1:0]     RST_HEIGHT = 16'd480;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

endpackage

// ===== hw/rtl/window3x3_image_filter_top.sv =====
// ----------------------------------------------------------------------------
// window3x3_image_filter_top: 3x3 neighbourhood filter on an RGB raster stream
// Row stores, window registers, position tracking and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one pixel per transaction in raster
//   order; flush transactions carry no pixel and drain the window. Send
//   image_width+1 flush transactions after each frame.
//   Output channel (out_valid/out_ready): one filtered pixel per result,
//   frame_end high on the last pixel of a frame.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//   index 0 mode, 1 image width, 2 image height. Write only when idle.
// Path: a result passes the s1 registers, the window and s2 registers and the
//   output register after the transaction that completes its window; results
//   trail input by image_width+1 transactions.
// Throughput: one transaction per cycle while the output is not held, set by a
//   three-stage pipeline (row store read, window shift, filter arithmetic).
// Reset: position counters, window and valid bits clear; registers take
//   mode mean, 640 x 480. Row stores are not cleared.
// Stall: when the output is held, the whole pipeline holds and in_ready
//   drops in the same cycle.
// ----------------------------------------------------------------------------
module window3x3_image_filter_top import w3f_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  input  logic                 flush,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic                 frame_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WB > RAW_WID_W) ? WB : RAW_WID_W;

  logic [MODE_W-1:0]    mode;
  logic [RAW_WID_W-1:0] wid_raw;
  logic [HGT_W-1:0]     hgt_raw;
  logic [EW-1:0]        w_eff;
  logic [HGT_W-1:0]     h_eff;

  logic [CW-1:0]    in_column, in_column_next;
  logic [ROW_W-1:0] in_row, in_row_next;

  logic             advance, accept;
  logic             wrap, emit_now, end_now;
  logic [CW-1:0]    c0, pc;
  logic [ROW_W-1:0] r0, pr;
  logic [EW-1:0]    c1;
  border_t          brd_now;

  logic             s1_valid, s1_emit, s1_end;
  border_t          s1_brd;
  pix_t             s1_px;
  logic [CW-1:0]    s1_col;
  logic             s2_valid, s2_emit, s2_end;
  border_t          s2_brd;

  pix_t store_a [MAX_WIDTH];
  pix_t store_b [MAX_WIDTH];
  pix_t rd_a, rd_b;
  pix_t win [9];
  pix_t res;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign accept    = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= RST_MODE;
      wid_raw <= RST_WIDTH;
      hgt_raw <= RST_HEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:   mode    <= cfg_data[MODE_W-1:0];
        REG_WIDTH:  wid_raw <= cfg_data[RAW_WID_W-1:0];
        REG_HEIGHT: hgt_raw <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_comb begin
    w_eff = EW'(wid_raw);
    if (w_eff < EW'(3)) w_eff = EW'(3);
    if (w_eff > EW'(MAX_WIDTH)) w_eff = EW'(MAX_WIDTH);
    h_eff = (hgt_raw < 16'd3) ? 16'd3 : hgt_raw;

    wrap = EW'(in_column) >= w_eff;
    c0   = wrap ? '0 : in_column;
    r0   = wrap ? in_row + 1'b1 : in_row;
    emit_now = !((r0 == '0) || (r0 == ROW_W'(1) && c0 == '0));
    if (c0 != '0) begin
      pc = c0 - 1'b1;
      pr = r0 - 1'b1;
    end else begin
      pc = CW'(w_eff - 1'b1);
      pr = r0 - ROW_W'(2);
    end
    brd_now.top    = pr != '0;
    brd_now.bottom = (pr + 1'b1) < ROW_W'(h_eff);
    brd_now.left   = pc != '0;
    brd_now.right  = (EW'(pc) + 1'b1) < w_eff;
    end_now = emit_now && ((pr >= ROW_W'(h_eff)) ||
              (pr == ROW_W'(h_eff) - 1'b1 && EW'(pc) == w_eff - 1'b1));

    c1 = EW'(c0) + 1'b1;
    if (c1 >= w_eff) begin
      in_column_next = '0;
      in_row_next    = r0 + 1'b1;
    end else begin
      in_column_next = c1[CW-1:0];
      in_row_next    = r0;
    end
    if (end_now) begin
      in_column_next = '0;
      in_row_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
    end else if (accept) begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_a <= store_a[c0];
      rd_b <= store_b[c0];
    end
    if (advance && s1_valid) begin
      store_a[s1_col] <= s1_px;
      store_b[s1_col] <= rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid && s2_emit;
      if (s1_valid) begin
        for (int i = 0; i < 3; i++) begin
          win[i*3]   <= win[i*3+1];
          win[i*3+1] <= win[i*3+2];
        end
        win[2] <= rd_b;
        win[5] <= rd_a;
        win[8] <= s1_px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_px   <= flush ? '0 : {in_red, in_green, in_blue};
      s1_col  <= c0;
      s1_emit <= emit_now;
      s1_end  <= end_now;
      s1_brd  <= brd_now;
      s2_emit <= s1_emit;
      s2_end  <= s1_end;
      s2_brd  <= s1_brd;
      out_red   <= res.r;
      out_green <= res.g;
      out_blue  <= res.b;
      frame_end <= s2_end;
    end
  end

  w3f_calc u_calc (
    .win  (win),
    .brd  (s2_brd),
    .mode (mode),
    .res  (res)
  );

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && end_now) |=> (in_column == '0 && in_row == '0))
    else $error("position counters not cleared after frame end");

  a_bubble: assert property (@(posedge clk) disable iff (rst)
    (advance && !in_valid) |=> !s1_valid)
    else $error("pipeline took an item that was not offered");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid && !s2_valid))
    else $error("pipeline not empty after reset");

endmodule

// ===== hw/rtl/w3f_calc.sv =====
// ----------------------------------------------------------------------------
// w3f_calc: 3x3 neighbourhood arithmetic
// Mean, laplacian, min, max and median of one window, border handling.
// ----------------------------------------------------------------------------
module w3f_calc import w3f_pkg::*; (
  input  pix_t              win [9],
  input  border_t           brd,
  input  logic [MODE_W-1:0] mode,
  output pix_t              res
);

  function automatic logic [7:0] div9(input logic [11:0] s);
    logic [23:0] p;
    p = s * 12'd3641;
    return p[22:15];
  endfunction

  function automatic logic [7:0] clip(input logic [7:0] c, input logic [11:0] s);
    logic signed [13:0] d;
    d = $signed({3'b000, c, 3'b000} + {6'b0, c}) - $signed({2'b00, s});
    if (d < 0) return 8'd0;
    if (d > 14'sd255) return 8'd255;
    return d[7:0];
  endfunction

  logic [11:0] sr, sg, sb;
  logic [7:0]  mn, mx, md;
  logic        inner;
  logic [3:0]  rank [9];
  logic        use_min [9];
  pix_t        ctr;

  always_comb begin
    ctr = win[4];
    inner = brd.top & brd.bottom & brd.left & brd.right;
    sr = '0;
    sg = '0;
    sb = '0;
    mx = '0;
    mn = ctr.r;
    md = '0;
    for (int i = 0; i < 9; i++) begin
      sr = sr + 12'(win[i].r);
      sg = sg + 12'(win[i].g);
      sb = sb + 12'(win[i].b);
      if (win[i].r > mx) mx = win[i].r;
      use_min[i] = !((i < 3 && !brd.top) || (i > 5 && !brd.bottom) ||
                     (i % 3 == 0 && !brd.left) || (i % 3 == 2 && !brd.right));
      if (use_min[i] && win[i].r < mn) mn = win[i].r;
      rank[i] = '0;
      for (int j = 0; j < 9; j++) begin
        if (win[j].r < win[i].r || (win[j].r == win[i].r && j < i))
          rank[i] = rank[i] + 4'd1;
      end
    end
    for (int i = 0; i < 9; i++) begin
      if (rank[i] == 4'd4) md = win[i].r;
    end

    res = ctr;
    case (mode)
      MODE_MIN:    res = '{mn, mn, mn};
      MODE_MEAN:   if (inner) res = '{div9(sr), div9(sg), div9(sb)};
      MODE_LAPL:   if (inner) res = '{clip(ctr.r, sr), clip(ctr.g, sg), clip(ctr.b, sb)};
      MODE_MAX:    if (inner) res = '{mx, mx, mx};
      MODE_MEDIAN: if (inner) res = '{md, md, md};
      default:     res = ctr;
    endcase
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: 3x3 window filter on an RGB raster stream
// Sends frames of pixels plus drain flushes through the input channel and
// predicts every filtered pixel with a behavioural copy of the filter.
// Covers all modes, the size extremes, mid-frame resize, flush pixels and
// pixels during drain, under several send/receive idling phases.
// ----------------------------------------------------------------------------
module testbench;
  import w3f_pkg::*;

  localparam int          MAXW        = DEF_MAX_WIDTH;
  localparam int          CYCLE_LIMIT = 50000;
  localparam logic [2:0]  MODE_LAST   = 3'd7;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       fe;
  } filt_pix_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_red = '0;
  logic [7:0]           in_green = '0;
  logic [7:0]           in_blue = '0;
  logic                 flush = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_red;
  logic [7:0]           out_green;
  logic [7:0]           out_blue;
  logic                 frame_end;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  window3x3_image_filter_top dut (.*);

  // filter state copy
  pix_t        line_a [MAXW];
  pix_t        line_b [MAXW];
  pix_t        win [9];
  int unsigned col_pos, row_pos;
  logic [2:0]  cur_mode;
  int unsigned cur_width, cur_height;

  filt_pix_t   pending_pix [$];
  int          errors = 0;
  int          pixels_sent = 0;
  int          pixels_checked = 0;
  int          frames_done = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  int unsigned cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int chan(pix_t p, int k);
    case (k)
      0: return int'(p.r);
      1: return int'(p.g);
      default: return int'(p.b);
    endcase
  endfunction

  function automatic void add_expected(filt_pix_t e);
    pending_pix = {pending_pix, e};
  endfunction

  function automatic void filter_step(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      logic fl);
    int unsigned w, h, col;
    longint t, p, total, rr, cc;
    bit top, bottom, left, right, inner;
    pix_t px, ctr;
    logic [23:0] res;
    int m, s, d, v, x, j;
    int reds [9];
    filt_pix_t e;
    w = cur_width < 3 ? 3 : (cur_width > MAXW ? MAXW : cur_width);
    h = cur_height < 3 ? 3 : cur_height;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    px = fl ? '0 : {r, g, b};
    col = col_pos;
    for (int i = 0; i < 3; i++) begin
      win[i*3]   = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = line_b[col];
    win[5] = line_a[col];
    win[8] = px;
    line_b[col] = line_a[col];
    line_a[col] = px;
    t = longint'(row_pos) * w + col_pos;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (t < w + 1) return;
    p = t - (w + 1);
    total = longint'(w) * h;
    rr = p / w;
    cc = p % w;
    top = rr > 0;
    bottom = rr + 1 < h;
    left = cc > 0;
    right = cc + 1 < w;
    inner = top && bottom && left && right;
    ctr = win[4];
    res = ctr;
    if (cur_mode == MODE_MIN) begin
      m = int'(ctr.r);
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++)
          if (!((i == 0 && !top) || (i == 2 && !bottom) ||
                (k == 0 && !left) || (k == 2 && !right)))
            if (int'(win[i*3+k].r) < m) m = int'(win[i*3+k].r);
      res = {3{m[7:0]}};
    end else if (inner && (cur_mode == MODE_MEAN || cur_mode == MODE_LAPL)) begin
      for (int k = 0; k < 3; k++) begin
        s = 0;
        for (int i = 0; i < 9; i++) s += chan(win[i], k);
        if (cur_mode == MODE_MEAN) begin
          v = s / 9;
        end else begin
          d = 9 * chan(ctr, k) - s;
          v = d < 0 ? 0 : (d > 255 ? 255 : d);
        end
        res[16-8*k +: 8] = v[7:0];
      end
    end else if (inner && cur_mode == MODE_MAX) begin
      m = 0;
      for (int i = 0; i < 9; i++) if (int'(win[i].r) > m) m = int'(win[i].r);
      res = {3{m[7:0]}};
    end else if (inner && cur_mode == MODE_MEDIAN) begin
      for (int i = 0; i < 9; i++) begin
        x = int'(win[i].r);
        j = i;
        while (j > 0 && reds[j-1] > x) begin
          reds[j] = reds[j-1];
          j--;
        end
        reds[j] = x;
      end
      m = reds[4];
      res = {3{m[7:0]}};
    end
    e.fe = (p + 1 >= total);
    if (e.fe) begin
      row_pos = 0;
      col_pos = 0;
    end
    e.r = res[23:16];
    e.g = res[15:8];
    e.b = res[7:0];
    add_expected(e);
  endfunction

  always @(posedge clk) begin
    filt_pix_t e;
    out_ready <= ($urandom_range(99) >= recv_stall);
    if (out_valid && out_ready) begin
      if (pending_pix.size() == 0) begin
        $error("unexpected pixel r=%0d g=%0d b=%0d", out_red, out_green, out_blue);
        errors++;
      end else begin
        e = pending_pix.pop_front();
        pixels_checked++;
        if (frame_end) frames_done++;
        if (out_red !== e.r) begin
          $error("out_red: expected %0d, got %0d", e.r, out_red);
          errors++;
        end
        if (out_green !== e.g) begin
          $error("out_green: expected %0d, got %0d", e.g, out_green);
          errors++;
        end
        if (out_blue !== e.b) begin
          $error("out_blue: expected %0d, got %0d", e.b, out_blue);
          errors++;
        end
        if (frame_end !== e.fe) begin
          $error("frame_end: expected %0d, got %0d", e.fe, frame_end);
          errors++;
        end
      end
    end
  end

  // valid stays high after the transaction; wait_idle or an idle phase of the next send drops it
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fl);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    flush    <= fl;
    do @(posedge clk); while (!in_ready);
    filter_step(r, g, b, fl);
    pixels_sent++;
  endtask

  task automatic send_random_pixel();
    logic [23:0] v;
    v = 24'($urandom);
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      default: ;
    endcase
    send_pixel(v[23:16], v[15:8], v[7:0], $urandom_range(19) == 0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MODE:   cur_mode = val[2:0];
      REG_WIDTH:  cur_width = 32'(val[RAW_WID_W-1:0]);
      REG_HEIGHT: cur_height = 32'(val);
      default: ;
    endcase
  endtask

  task automatic configure(logic [2:0] m, int unsigned w, int unsigned h);
    wait_idle();
    write_reg(REG_MODE, CFG_DAT_W'(m));
    write_reg(REG_WIDTH, CFG_DAT_W'(w));
    write_reg(REG_HEIGHT, CFG_DAT_W'(h));
  endtask

  // width+1 mostly-flush sends, then flushes until the position counters return to frame start
  task automatic drain_frame();
    int unsigned w;
    w = cur_width < 3 ? 3 : (cur_width > MAXW ? MAXW : cur_width);
    repeat (w + 1) send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                              $urandom_range(7) != 0);
    while (col_pos != 0 || row_pos != 0) send_pixel('0, '0, '0, 1'b1);
  endtask

  task automatic send_frame(logic [2:0] m, int unsigned w, int unsigned h);
    configure(m, w, h);
    repeat (w * h) send_random_pixel();
    drain_frame();
  endtask

  task automatic test_every_mode();
    for (int m = 0; m <= MODE_LAST; m++) begin
      configure(m[2:0], 3, 3);
      for (int i = 0; i < 9; i++)
        send_pixel(i == 4 ? 8'h00 : 8'hff, i == 4 ? 8'hff : 8'h00, 8'(i * 31), 1'b0);
      drain_frame();
    end
  endtask

  task automatic test_size_clamping();
    configure(MODE_LAPL, 2, 1);
    repeat (9) send_random_pixel();
    drain_frame();
    configure(MODE_MEDIAN, 5, 0);
    repeat (15) send_random_pixel();
    drain_frame();
    configure(MODE_MIN, 16'h07ff, 3);
    repeat (6) send_random_pixel();
    wait_idle();
    write_reg(REG_WIDTH, CFG_DAT_W'(5));
    repeat (15) send_random_pixel();
    drain_frame();
    configure(MODE_MAX, 4, 16'hffff);
    repeat (40) send_random_pixel();
    wait_idle();
    write_reg(REG_HEIGHT, CFG_DAT_W'(3));
    drain_frame();
  endtask

  task automatic test_resize_midframe();
    configure(MODE_MEAN, 6, 5);
    repeat (14) send_random_pixel();
    wait_idle();
    write_reg(REG_WIDTH, CFG_DAT_W'(4));
    write_reg(REG_MODE, CFG_DAT_W'(MODE_MIN));
    repeat (10) send_random_pixel();
    drain_frame();
  endtask

  task automatic test_random_frames(int idle_pct, int stall_pct);
    int stop_at;
    send_idle = idle_pct;
    recv_stall = stall_pct;
    stop_at = pixels_sent + 40;
    while (pixels_sent < stop_at)
      send_frame(3'($urandom_range(MODE_LAST)), $urandom_range(3, 9),
                 $urandom_range(3, 5));
  endtask

  initial begin
    foreach (line_a[i]) begin
      line_a[i] = '0;
      line_b[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
    cur_mode = RST_MODE;
    cur_width = 32'(RST_WIDTH);
    cur_height = 32'(RST_HEIGHT);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_every_mode();
    test_size_clamping();
    test_resize_midframe();
    test_random_frames(0, 0);
    test_random_frames(49, 0);
    test_random_frames(0, 49);
    test_random_frames(35, 35);
    wait_idle();
    repeat (20) @(posedge clk);
    $display("Sent %0d pixels over %0d frames, checked %0d filtered pixels,",
             pixels_sent, frames_done, pixels_checked);
    $display("all eight mode codes, clamped sizes, mid-frame resize and idling phases.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
